>>> rtl/deq_pkg.sv
// Shared constants and codes for the double-ended queue block.
`timescale 1ns / 1ps

package deq_pkg;

    // Default storage depth and data width.
    localparam int DEF_DEPTH  = 256;
    localparam int DATA_W     = 32;
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 2;

    // Command codes.
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ROT_LEFT   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ROT_RIGHT  = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Value returned when a pop or rotate finds the queue empty.
    localparam logic signed [DATA_W-1:0] VAL_EMPTY = -32'sd1;
    localparam logic signed [DATA_W-1:0] VAL_ZERO  = 32'sd0;

endpackage

>>> rtl/double_ended_queue_top.sv
// Double-ended queue: ring store in RAM, head pointer and element count in registers.
// Push and every empty or unused command load the result register at accept; pop and rotate go
// through the registered read of the ring RAM, then the result register, and a rotate writes its
// element back as the read data arrives. Throughput: one request per cycle for pushes when the
// output register is free or draining; a pop or rotate holds off new requests until it is done.
// Reset: synchronous, active low; clears state, head, count and output valid. RAM is not cleared.
`timescale 1ns / 1ps

module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ACTION_W-1:0]              i_action,
    input  logic signed [DATA_W-1:0]         i_push_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [DATA_W-1:0]         o_result_value,
    output logic [STATUS_W-1:0]              o_status,
    output logic [$clog2(DEPTH+1)-1:0]       o_fill_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // Ring index of a plus b, with a below DEPTH and b at most DEPTH.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    logic              r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rot, n_rot;
    logic [IDX_W-1:0]  r_wb_addr, n_wb_addr;

    logic                      r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0]  r_result, n_result;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic [CNT_W-1:0]          r_fill, n_fill;

    logic              accept;
    logic              is_empty, is_full;
    logic [IDX_W-1:0]  head_dec, head_inc, back_slot, tail_slot;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    // A new request is taken only in idle, when the output register is free or draining.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Ring positions derived from the current head and count.
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign head_dec  = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc  = wrap_add(r_head, CNT_W'(1));
    assign back_slot = wrap_add(r_head, r_count);
    assign tail_slot = wrap_add(r_head, r_count - 1'b1);

    // Read address: front element or back element.
    always_comb begin
        case (i_action) inside
            ACT_POP_BACK, ACT_ROT_RIGHT: ram_raddr = tail_slot;
            default:                     ram_raddr = r_head;
        endcase
    end

    // Writes: pushes at accept, rotate write-back in the read cycle.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wb_addr;
        ram_wdata = ram_rdata;
        if (r_state == ST_READ) begin
            ram_we = r_rot;
        end else if (accept && !is_full) begin
            case (i_action)
                ACT_PUSH_FRONT: begin
                    ram_we    = 1'b1;
                    ram_waddr = head_dec;
                    ram_wdata = i_push_value;
                end
                ACT_PUSH_BACK: begin
                    ram_we    = 1'b1;
                    ram_waddr = back_slot;
                    ram_wdata = i_push_value;
                end
                default: ram_we = 1'b0;
            endcase
        end
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Command decode, pointer update and result register.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_rot       = r_rot;
        n_wb_addr   = r_wb_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_result    = r_result;
        n_status    = r_status;
        n_fill      = r_fill;

        if (r_state == ST_READ) begin
            // Read data is back: deliver it.
            n_state     = ST_IDLE;
            n_out_valid = 1'b1;
            n_result    = ram_rdata;
            n_status    = STAT_OK;
            n_fill      = r_count;
        end else if (accept) begin
            n_rot = 1'b0;
            case (i_action) inside
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    n_out_valid = 1'b1;
                    n_result    = VAL_ZERO;
                    if (is_full) begin
                        n_status = STAT_FULL;
                        n_fill   = r_count;
                    end else begin
                        n_status = STAT_OK;
                        n_count  = r_count + 1'b1;
                        n_fill   = r_count + 1'b1;
                        if (i_action == ACT_PUSH_FRONT) begin
                            n_head = head_dec;
                        end
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK, ACT_ROT_LEFT, ACT_ROT_RIGHT: begin
                    if (is_empty) begin
                        n_out_valid = 1'b1;
                        n_result    = VAL_EMPTY;
                        n_status    = STAT_EMPTY;
                        n_fill      = r_count;
                    end else begin
                        n_state = ST_READ;
                        case (i_action)
                            ACT_POP_FRONT: begin
                                n_head  = head_inc;
                                n_count = r_count - 1'b1;
                            end
                            ACT_POP_BACK: begin
                                n_count = r_count - 1'b1;
                            end
                            ACT_ROT_LEFT: begin
                                n_rot     = 1'b1;
                                n_wb_addr = back_slot;
                                n_head    = head_inc;
                            end
                            default: begin
                                n_rot     = 1'b1;
                                n_wb_addr = head_dec;
                                n_head    = head_dec;
                            end
                        endcase
                    end
                end
                default: begin
                    // Unused codes are answered and change nothing.
                    n_out_valid = 1'b1;
                    n_result    = VAL_ZERO;
                    n_status    = STAT_OK;
                    n_fill      = r_count;
                end
            endcase
        end
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rot       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rot       <= n_rot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= n_wb_addr;
        r_result  <= n_result;
        r_status  <= n_status;
        r_fill    <= n_fill;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;
    assign o_fill_count   = r_fill;

endmodule

>>> rtl/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> bench/tb_double_ended_queue_top.sv
// Self-checking testbench for the double-ended queue with a scoreboard of predicted results.
`timescale 1ns / 1ps

module tb_double_ended_queue_top;
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEF_DEPTH + 1);
    localparam int PTR_W = $clog2(DEF_DEPTH);

    // Action codes the block must ignore.
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef enum int {MODE_MIX, MODE_FILL, MODE_HOLD, MODE_DRAIN} traffic_mode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic [CNT_W-1:0]         count;
    } deq_result_t;

    // Queue predictor and the store of results still owed by the block.
    class deq_scoreboard;
        logic [DATA_W-1:0] ring [DEF_DEPTH];
        logic [PTR_W-1:0]  head;
        logic [CNT_W-1:0]  fill;
        deq_result_t       owed [$];
        int                errors;
        int                seen;

        function new();
            head   = '0;
            fill   = '0;
            errors = 0;
            seen   = 0;
        endfunction

        // The depth is a power of two, so pointer arithmetic wraps by truncation.
        function void note_request(input logic [ACTION_W-1:0] act,
                                   input logic signed [DATA_W-1:0] val);
            deq_result_t      res;
            logic [PTR_W-1:0] slot;
            res.value  = VAL_ZERO;
            res.status = STAT_OK;
            case (act)
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (fill == DEF_DEPTH) begin
                        res.status = STAT_FULL;
                    end else if (act == ACT_PUSH_FRONT) begin
                        head       = head - 1'b1;
                        ring[head] = val;
                        fill       = fill + 1'b1;
                    end else begin
                        slot       = head + fill[PTR_W-1:0];
                        ring[slot] = val;
                        fill       = fill + 1'b1;
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK, ACT_ROT_LEFT, ACT_ROT_RIGHT: begin
                    if (fill == 0) begin
                        res.value  = VAL_EMPTY;
                        res.status = STAT_EMPTY;
                    end else begin
                        case (act)
                            ACT_POP_FRONT: begin
                                res.value = ring[head];
                                head      = head + 1'b1;
                                fill      = fill - 1'b1;
                            end
                            ACT_POP_BACK: begin
                                slot      = head + fill[PTR_W-1:0] - 1'b1;
                                res.value = ring[slot];
                                fill      = fill - 1'b1;
                            end
                            ACT_ROT_LEFT: begin
                                // On a full queue the write lands on the head slot itself.
                                res.value  = ring[head];
                                slot       = head + fill[PTR_W-1:0];
                                ring[slot] = res.value;
                                head       = head + 1'b1;
                            end
                            default: begin
                                slot       = head + fill[PTR_W-1:0] - 1'b1;
                                res.value  = ring[slot];
                                head       = head - 1'b1;
                                ring[head] = res.value;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
            res.count = fill;
            owed.push_back(res);
        endfunction

        task report_mismatch(input string field, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
            $display("Mismatch on result %0d: %s got 0x%08h, predicted 0x%08h",
                     seen, field, got, want);
            errors++;
        endtask

        task check_result(input logic signed [DATA_W-1:0] value,
                          input logic [STATUS_W-1:0] status,
                          input logic [CNT_W-1:0] count);
            deq_result_t want;
            seen++;
            if (owed.size() == 0) begin
                report_mismatch("unrequested result", value, '0);
            end else begin
                want = owed.pop_front();
                if (value !== want.value)
                    report_mismatch("result_value", value, want.value);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (count !== want.count)
                    report_mismatch("fill_count", count, want.count);
            end
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [ACTION_W-1:0]        action = '0;
    logic signed [DATA_W-1:0]   push_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [DATA_W-1:0]   result_value;
    logic [STATUS_W-1:0]        status;
    logic [CNT_W-1:0]           fill_count;

    deq_scoreboard sb;
    int            burst_left = 0;
    int            stall_mode = 0;
    int            mode_left = 0;
    int            stall_left = 0;
    int            tick = 0;

    double_ended_queue_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (action),
        .i_push_value   (push_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_value (result_value),
        .o_status       (status),
        .o_fill_count   (fill_count)
    );

    // Clock with a 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls: the stall pattern is chosen at random from four modes and changes over the run.
    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        tick++;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= (tick % 3 == 0);
            default: begin
                if (stall_left > 0) begin
                    out_ready <= 1'b0;
                    stall_left--;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 10);
                end
            end
        endcase
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_value, status, fill_count);
    end

    // Present one request and hold it until accepted; the sender may idle between bursts.
    task send_request(input logic [ACTION_W-1:0] act, input logic signed [DATA_W-1:0] val);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        action     <= act;
        push_value <= val;
        do @(posedge clk); while (!in_ready);
        sb.note_request(act, val);
    endtask

    // Drop valid, then hold off until the block owes nothing.
    task drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Values lean toward the extremes now and then.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // One random request, its mix of commands set by the traffic mode.
    task send_random(input traffic_mode_t mode);
        int                  r;
        int                  push_pct;
        int                  pop_pct;
        logic [ACTION_W-1:0] act;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                push_pct = 88;
                pop_pct  = 4;
            end
            MODE_DRAIN: begin
                push_pct = 6;
                pop_pct  = 86;
            end
            MODE_HOLD: begin
                push_pct = 50;
                pop_pct  = 8;
            end
            default: begin
                push_pct = 35;
                pop_pct  = 30;
            end
        endcase
        if (r < push_pct)
            act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        else if (r < push_pct + pop_pct)
            act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        else if (r < 97)
            act = $urandom_range(0, 1) ? ACT_ROT_RIGHT : ACT_ROT_LEFT;
        else
            act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
        send_request(act, pick_value());
    endtask

    // Main sequence.
    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-queue commands, spare codes, extreme values, every command.
        send_request(ACT_POP_FRONT, 32'sd5);
        send_request(ACT_POP_BACK, -32'sd5);
        send_request(ACT_ROT_LEFT, 32'sd0);
        send_request(ACT_ROT_RIGHT, 32'sd0);
        send_request(ACT_SPARE_6, 32'sh1234_5678);
        send_request(ACT_SPARE_7, -32'sd1);
        send_request(ACT_PUSH_FRONT, 32'sh7fff_ffff);
        send_request(ACT_PUSH_BACK, 32'sh8000_0000);
        send_request(ACT_PUSH_FRONT, -32'sd1);
        send_request(ACT_PUSH_BACK, 32'sd0);
        send_request(ACT_ROT_LEFT, 32'sd0);
        send_request(ACT_ROT_RIGHT, 32'sd0);
        send_request(ACT_SPARE_6, 32'sh5555_5555);
        send_request(ACT_POP_FRONT, 32'sd0);
        send_request(ACT_POP_BACK, 32'sd0);
        send_request(ACT_SPARE_7, 32'shaaaa_aaaa);
        send_request(ACT_POP_FRONT, 32'sd0);
        send_request(ACT_POP_BACK, 32'sd0);
        send_request(ACT_POP_FRONT, 32'sd0);
        send_request(ACT_PUSH_BACK, 32'sh5555_5555);
        send_request(ACT_PUSH_FRONT, 32'shaaaa_aaaa);
        send_request(ACT_ROT_LEFT, 32'sd0);
        send_request(ACT_ROT_RIGHT, 32'sd0);
        send_request(ACT_POP_BACK, 32'sd0);
        send_request(ACT_POP_FRONT, 32'sd0);

        // Random: mixed traffic, then fill to the top and work the full queue.
        repeat (150) send_random(MODE_MIX);
        while (sb.fill < DEF_DEPTH) send_random(MODE_FILL);
        repeat (40) send_random(MODE_HOLD);
        drain_results();

        // Empty it out, keep going on the empty queue, then mixed traffic to the end.
        while (sb.fill != 0) send_random(MODE_DRAIN);
        repeat (25) send_random(MODE_DRAIN);
        repeat (200) send_random(MODE_MIX);
        repeat (300) send_random(MODE_MIX);

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
